/* rtl/core/eei_pkg.sv */
`default_nettype none

package eei_pkg;

  // Field widths
  localparam int unsigned ENTITY_W = 6;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned Q_W      = 32;

  // Table size: the entity field reaches at most this many slots
  localparam int unsigned MAX_SLOTS            = 2 ** ENTITY_W;
  localparam int unsigned DEFAULT_MAX_ENTITIES = 64;

  typedef logic signed [Q_W-1:0] q16_t;
  typedef q16_t [2:0] vec3_t;

  // One entity record as held in the table memory
  typedef struct packed {
    vec3_t pos;
    vec3_t orient;
    vec3_t vel;
    vec3_t torq;
  } ent_rec_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET_POS    = 3'd0,
    OP_ADD_TORQUE = 3'd1,
    OP_ADD_VEL    = 3'd2,
    OP_TICK       = 3'd3,
    OP_ADD_ENT    = 3'd4,
    OP_REMOVE     = 3'd5
  } opcode_t;

  typedef enum logic {
    ALU_ADD,
    ALU_MAC
  } alu_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_READ,
    S_LOAD,
    S_CALC,
    S_ACCUM,
    S_WRITE,
    S_REPORT
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/eei_ram.sv */
`default_nettype none

module eei_ram #(
  parameter int unsigned DEPTH = eei_pkg::DEFAULT_MAX_ENTITIES,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire eei_pkg::ent_rec_t wdata,
  output eei_pkg::ent_rec_t     rdata
);
  import eei_pkg::*;

  ent_rec_t mem [DEPTH];

  // One write port, registered read at the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/core/eei_alu.sv */
`default_nettype none

module eei_alu (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire eei_pkg::alu_mode_t mode,
  input  wire eei_pkg::q16_t      a,
  input  wire eei_pkg::q16_t      b,
  input  wire logic [31:0]        dt,
  output eei_pkg::q16_t           result
);
  import eei_pkg::*;

  localparam int unsigned SUM_W = 50;

  logic [31:0] mag;
  logic [63:0] prod;
  logic [63:0] prod_q;
  logic        neg_q;
  q16_t        a_q;
  q16_t        b_q;
  alu_mode_t   mode_q;
  logic [SUM_W-1:0] mag_ext;
  logic [SUM_W-1:0] term;
  logic [SUM_W-1:0] sum;
  logic             fits;

  // Stage 1: magnitude times delta, registered
  assign mag  = b[31] ? 32'(-b) : 32'(b);
  assign prod = mag * dt;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_q <= prod;
      neg_q  <= b[31];
      a_q    <= a;
      b_q    <= b;
      mode_q <= mode;
    end
  end

  // Stage 2: in MAC mode truncate toward zero and restore sign; add and saturate
  assign mag_ext = {2'b00, prod_q[63:16]};

  always_comb begin
    if (mode_q == ALU_MAC) begin
      term = neg_q ? (~mag_ext + 1'b1) : mag_ext;
    end else begin
      term = {{(SUM_W-32){b_q[31]}}, b_q};
    end
  end

  assign sum  = {{(SUM_W-32){a_q[31]}}, a_q} + term;
  assign fits = (&sum[SUM_W-1:31]) | ~(|sum[SUM_W-1:31]);

  always_comb begin
    if (fits) begin
      result = q16_t'(sum[31:0]);
    end else if (sum[SUM_W-1]) begin
      result = q16_t'(32'h8000_0000);
    end else begin
      result = q16_t'(32'h7FFF_FFFF);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/entity_euler_integrator.sv */
// Set position / add entity go through check, read, load, write and report; add torque or
//   velocity also run calc/accumulate for each axis; remove and error cases go check to report.
// Tick: scans MAX_ENTITIES slots (capped at 64) and updates each valid entity with
//   the single multiply-add unit doing six axes one after another.
// One word at a time: busy stays high until the result strobe; done is a 1-cycle pulse.
// Reset (rst, synchronous) clears all valid flags; the table memory is not cleared.
`default_nettype none

module entity_euler_integrator #(
  parameter int unsigned MAX_ENTITIES = eei_pkg::DEFAULT_MAX_ENTITIES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [eei_pkg::OPCODE_W-1:0]   opcode,
  input  wire logic [eei_pkg::ENTITY_W-1:0]   entity,
  input  wire logic signed [eei_pkg::Q_W-1:0] x_value,
  input  wire logic signed [eei_pkg::Q_W-1:0] y_value,
  input  wire logic signed [eei_pkg::Q_W-1:0] z_value,
  input  wire logic [eei_pkg::Q_W-1:0]        tick_dt,
  output logic                                done,
  output logic                                status,
  output logic [eei_pkg::ENTITY_W-1:0]        entity_echo,
  output logic signed [eei_pkg::Q_W-1:0]      pos_x_out,
  output logic signed [eei_pkg::Q_W-1:0]      pos_y_out,
  output logic signed [eei_pkg::Q_W-1:0]      pos_z_out,
  output logic signed [eei_pkg::Q_W-1:0]      orient_x_out,
  output logic signed [eei_pkg::Q_W-1:0]      orient_y_out,
  output logic signed [eei_pkg::Q_W-1:0]      orient_z_out
);
  import eei_pkg::*;

  localparam int unsigned NUM_SLOTS = (MAX_ENTITIES < MAX_SLOTS) ? MAX_ENTITIES : MAX_SLOTS;
  localparam int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  state_t state;
  state_t state_next;

  // Latched command word
  logic [OPCODE_W-1:0] op_q;
  logic [ENTITY_W-1:0] entity_q;
  logic                in_tab_q;
  vec3_t               in_vec;
  logic [Q_W-1:0]      dt_q;

  logic [IDX_W-1:0]    addr;
  logic [1:0]          axis;
  logic                phase;
  logic [NUM_SLOTS-1:0] valid;
  ent_rec_t            rec;
  ent_rec_t            ram_rdata;
  logic                err_q;
  logic                show_q;

  logic      is_tick;
  logic      is_add;
  logic      present;
  logic      last;
  logic      accept;
  logic      err;
  alu_mode_t alu_mode;
  q16_t      alu_a;
  q16_t      alu_b;
  q16_t      alu_res;

  // FSM outputs
  logic ram_we;
  logic alu_load;
  logic chk_en;
  logic load_en;
  logic acc_en;
  logic rep_en;
  logic addr_inc;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign is_tick = (op_q == OP_TICK);
  assign is_add  = (op_q == OP_ADD_TORQUE) || (op_q == OP_ADD_VEL);
  assign present = in_tab_q && valid[addr];
  assign last    = (addr == IDX_W'(NUM_SLOTS - 1));

  // Error condition decided in the check state
  always_comb begin
    unique case (op_q)
      OP_SET_POS, OP_ADD_TORQUE, OP_ADD_VEL, OP_REMOVE: err = !present;
      OP_ADD_ENT:                                       err = !in_tab_q;
      default:                                          err = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (is_tick) begin
          state_next = S_SCAN;
        end else if (!err && (is_add || op_q == OP_SET_POS || op_q == OP_ADD_ENT)) begin
          state_next = S_READ;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_SCAN: begin
        if (valid[addr])  state_next = S_READ;
        else if (last)    state_next = S_REPORT;
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: begin
        state_next = (is_tick || is_add) ? S_CALC : S_WRITE;
      end
      S_CALC: state_next = S_ACCUM;
      S_ACCUM: begin
        if (axis == 2'd2 && !(is_tick && !phase)) state_next = S_WRITE;
        else                                       state_next = S_CALC;
      end
      S_WRITE: begin
        state_next = (is_tick && !last) ? S_SCAN : S_REPORT;
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ram_we   = 1'b0;
    alu_load = 1'b0;
    chk_en   = 1'b0;
    load_en  = 1'b0;
    acc_en   = 1'b0;
    rep_en   = 1'b0;
    addr_inc = 1'b0;
    unique case (state)
      S_CHECK:  chk_en   = 1'b1;
      S_SCAN:   addr_inc = !valid[addr] && !last;
      S_LOAD:   load_en  = 1'b1;
      S_CALC:   alu_load = 1'b1;
      S_ACCUM:  acc_en   = 1'b1;
      S_WRITE: begin
        ram_we   = 1'b1;
        addr_inc = is_tick && !last;
      end
      S_REPORT: rep_en   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= opcode;
      entity_q <= entity;
      in_tab_q <= ({1'b0, entity} < (ENTITY_W + 1)'(NUM_SLOTS));
      in_vec   <= {z_value, y_value, x_value};
      dt_q     <= tick_dt;
    end
  end

  // Table address: entity index, or scan pointer during a tick
  always_ff @(posedge clk) begin
    if (accept) begin
      addr <= entity[IDX_W-1:0];
    end else if (chk_en && is_tick) begin
      addr <= '0;
    end else if (addr_inc) begin
      addr <= addr + 1'b1;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (chk_en && op_q == OP_REMOVE && present) begin
      valid[addr] <= 1'b0;
    end else if (ram_we && op_q == OP_ADD_ENT) begin
      valid[addr] <= 1'b1;
    end
  end

  // Result kind decided in the check state
  always_ff @(posedge clk) begin
    if (chk_en) begin
      err_q  <= err;
      show_q <= !err && (is_add || op_q == OP_SET_POS || op_q == OP_ADD_ENT);
    end
  end

  // Axis sequencing: three axes, two passes for a tick
  always_ff @(posedge clk) begin
    if (load_en) begin
      axis  <= 2'd0;
      phase <= 1'b0;
    end else if (acc_en) begin
      if (axis == 2'd2) begin
        axis  <= 2'd0;
        phase <= 1'b1;
      end else begin
        axis <= axis + 2'd1;
      end
    end
  end

  // Operand select for the shared unit
  always_comb begin
    alu_mode = is_tick ? ALU_MAC : ALU_ADD;
    if (is_tick) begin
      alu_a = phase ? rec.orient[axis] : rec.pos[axis];
      alu_b = phase ? rec.torq[axis] : rec.vel[axis];
    end else if (op_q == OP_ADD_TORQUE) begin
      alu_a = rec.torq[axis];
      alu_b = in_vec[axis];
    end else begin
      alu_a = rec.vel[axis];
      alu_b = in_vec[axis];
    end
  end

  // Working record: load from table, update one axis per accumulate step
  always_ff @(posedge clk) begin
    if (load_en) begin
      if (op_q == OP_ADD_ENT && !valid[addr]) begin
        rec <= '0;
      end else if (op_q == OP_SET_POS) begin
        // new position, other vectors kept from the table
        rec <= {in_vec, ram_rdata.orient, ram_rdata.vel, ram_rdata.torq};
      end else begin
        rec <= ram_rdata;
      end
    end else if (acc_en) begin
      if (is_tick) begin
        if (phase) rec.orient[axis] <= alu_res;
        else       rec.pos[axis]    <= alu_res;
      end else if (op_q == OP_ADD_TORQUE) begin
        rec.torq[axis] <= alu_res;
      end else begin
        rec.vel[axis] <= alu_res;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rep_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_en) begin
      status       <= err_q;
      entity_echo  <= is_tick ? '0 : entity_q;
      pos_x_out    <= show_q ? rec.pos[0] : '0;
      pos_y_out    <= show_q ? rec.pos[1] : '0;
      pos_z_out    <= show_q ? rec.pos[2] : '0;
      orient_x_out <= show_q ? rec.orient[0] : '0;
      orient_y_out <= show_q ? rec.orient[1] : '0;
      orient_z_out <= show_q ? rec.orient[2] : '0;
    end
  end

  eei_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata (rec),
    .rdata (ram_rdata)
  );

  eei_alu u_alu (
    .clk    (clk),
    .load   (alu_load),
    .mode   (alu_mode),
    .a      (alu_a),
    .b      (alu_b),
    .dt     (dt_q),
    .result (alu_res)
  );

  // Checks
  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_REPORT))
    else $error("result strobe without report state");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CHECK))
    else $error("accepted word did not enter check");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (addr <= IDX_W'(NUM_SLOTS - 1)))
    else $error("table write outside the entity range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (pos_x_out == 0 && orient_z_out == 0))
    else $error("error result carries vector data");

endmodule

`default_nettype wire

/* dv/tb_entity_euler_integrator.sv */
`timescale 1ns / 1ps

module tb_entity_euler_integrator;
  import eei_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEFAULT_MAX_ENTITIES;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYCLES = 1100;

  // opcodes the block treats as no-ops
  localparam logic [OPCODE_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_B = 3'd7;

  localparam q16_t Q_MAX = 32'sh7fff_ffff;
  localparam q16_t Q_MIN = 32'sh8000_0000;
  localparam q16_t Q_ONE = 32'sh0001_0000;

  // one reply word as seen on the result ports
  typedef struct {
    bit                status;
    bit [ENTITY_W-1:0] echo;
    vec3_t             pos;
    vec3_t             orient;
  } reply_t;

  // Shadow of the entity table; predicts the reply to each accepted command
  class entity_table_tracker;
    bit          live   [MAX_SLOTS];
    vec3_t       pos    [MAX_SLOTS];
    vec3_t       orient [MAX_SLOTS];
    vec3_t       vel    [MAX_SLOTS];
    vec3_t       torq   [MAX_SLOTS];
    reply_t      pending [$];
    int unsigned errors;

    function q16_t saturate(longint s);
      if (s > 64'sd2147483647) return Q_MAX;
      if (s < -64'sd2147483648) return Q_MIN;
      return q16_t'(s);
    endfunction

    // acc + rate * dt, product truncated toward zero
    function q16_t euler_axis(q16_t acc, q16_t rate, logic [Q_W-1:0] dt);
      bit [63:0] mag;
      bit [63:0] prod;
      longint    q;
      mag  = (rate < 0) ? 64'(-longint'(rate)) : 64'(longint'(rate));
      prod = (mag * {32'b0, dt}) >> 16;
      q    = (rate < 0) ? -longint'(prod) : longint'(prod);
      return saturate(longint'(acc) + q);
    endfunction

    function vec3_t add_vec(vec3_t a, vec3_t b);
      vec3_t r;
      for (int k = 0; k < 3; k++) r[k] = saturate(longint'(a[k]) + longint'(b[k]));
      return r;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    function void note_command(logic [OPCODE_W-1:0] op, logic [ENTITY_W-1:0] ent,
                               q16_t x, q16_t y, q16_t z, logic [Q_W-1:0] dt);
      reply_t r;
      vec3_t  v;
      bit     in_table;
      bit     present;
      bit     show;
      in_table = ent < TABLE_DEPTH;
      present  = in_table && live[ent];
      show     = 1'b0;
      r.status = 1'b0;
      r.echo   = ent;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      case (op)
        OP_SET_POS, OP_ADD_TORQUE, OP_ADD_VEL: begin
          if (!present) begin
            r.status = 1'b1;
          end else begin
            if (op == OP_SET_POS) pos[ent] = v;
            else if (op == OP_ADD_TORQUE) torq[ent] = add_vec(torq[ent], v);
            else vel[ent] = add_vec(vel[ent], v);
            show = 1'b1;
          end
        end
        OP_TICK: begin
          r.echo = '0;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (live[i]) begin
              for (int k = 0; k < 3; k++) begin
                pos[i][k]    = euler_axis(pos[i][k], vel[i][k], dt);
                orient[i][k] = euler_axis(orient[i][k], torq[i][k], dt);
              end
            end
          end
        end
        OP_ADD_ENT: begin
          if (!in_table) begin
            r.status = 1'b1;
          end else begin
            // a present entity keeps its vectors
            if (!live[ent]) begin
              pos[ent]    = '0;
              orient[ent] = '0;
              vel[ent]    = '0;
              torq[ent]   = '0;
              live[ent]   = 1'b1;
            end
            show = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!present) r.status = 1'b1;
          else live[ent] = 1'b0;
        end
        default: ;
      endcase
      r.pos    = show ? pos[ent] : '0;
      r.orient = show ? orient[ent] : '0;
      pending.push_back(r);
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function void check_reply(logic st, logic [ENTITY_W-1:0] echo,
                              q16_t px, q16_t py, q16_t pz,
                              q16_t ox, q16_t oy, q16_t oz);
      reply_t e;
      if (pending.size() == 0) begin
        $error("reply word with no command outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      match("status", 32'(e.status), 32'(st));
      match("entity_echo", 32'(e.echo), 32'(echo));
      match("pos_x_out", e.pos[0], px);
      match("pos_y_out", e.pos[1], py);
      match("pos_z_out", e.pos[2], pz);
      match("orient_x_out", e.orient[0], ox);
      match("orient_y_out", e.orient[1], oy);
      match("orient_z_out", e.orient[2], oz);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [OPCODE_W-1:0] opcode = '0;
  logic [ENTITY_W-1:0] entity = '0;
  q16_t                x_value = '0;
  q16_t                y_value = '0;
  q16_t                z_value = '0;
  logic [Q_W-1:0]      tick_dt = '0;
  logic                done;
  logic                status;
  logic [ENTITY_W-1:0] entity_echo;
  q16_t                pos_x_out, pos_y_out, pos_z_out;
  q16_t                orient_x_out, orient_y_out, orient_z_out;

  entity_table_tracker tracker = new();
  bit                  eager = 1'b0;
  int unsigned         idle_cycles = 0;

  entity_euler_integrator u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .entity       (entity),
    .x_value      (x_value),
    .y_value      (y_value),
    .z_value      (z_value),
    .tick_dt      (tick_dt),
    .done         (done),
    .status       (status),
    .entity_echo  (entity_echo),
    .pos_x_out    (pos_x_out),
    .pos_y_out    (pos_y_out),
    .pos_z_out    (pos_z_out),
    .orient_x_out (orient_x_out),
    .orient_y_out (orient_y_out),
    .orient_z_out (orient_z_out)
  );

  always #4 clk = ~clk;

  // accepted commands and reply words, sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        tracker.note_command(opcode, entity, x_value, y_value, z_value, tick_dt);
      if (done)
        tracker.check_reply(status, entity_echo, pos_x_out, pos_y_out, pos_z_out,
                            orient_x_out, orient_y_out, orient_z_out);
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** entity_euler_integrator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one command word: optional gap, then hold start until accepted
  task automatic issue(input logic [OPCODE_W-1:0] op, input logic [ENTITY_W-1:0] ent,
                       input q16_t x, input q16_t y, input q16_t z,
                       input logic [Q_W-1:0] dt);
    int unsigned gap;
    gap = eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    entity     <= ent;
    x_value    <= x;
    y_value    <= y;
    z_value    <= z;
    tick_dt    <= dt;
    do @(posedge clk); while (busy);
  endtask

  // stop sending until every reply word is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  function automatic q16_t pick_value();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3:    return q16_t'($urandom);
      default: return q16_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [Q_W-1:0] pick_delta();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  initial begin
    int unsigned         n;
    int unsigned         roll;
    logic [OPCODE_W-1:0] op;
    logic [ENTITY_W-1:0] ent;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: absent entities, extremes, saturation, truncation, no-op codes
    issue(OP_SET_POS,    6'd5,  32'sd1, 32'sd2, 32'sd3, '0);
    issue(OP_REMOVE,     6'd5,  '0, '0, '0, '0);
    issue(OP_ADD_ENT,    6'd0,  Q_MAX, Q_MIN, '0, '0);
    issue(OP_ADD_ENT,    6'd63, '0, '0, '0, '1);
    issue(OP_ADD_ENT,    6'd0,  '0, '0, '0, '0);
    issue(OP_SET_POS,    6'd0,  Q_MAX, Q_MIN, '0, '0);
    issue(OP_ADD_VEL,    6'd0,  Q_MAX, Q_MIN, Q_ONE, '0);
    issue(OP_ADD_VEL,    6'd0,  Q_MAX, Q_MIN, -32'sd1, '0);
    issue(OP_ADD_TORQUE, 6'd63, Q_MIN, Q_MAX, 32'sh0001_8000, '0);
    issue(OP_SET_POS,    6'd63, -32'sd1, 32'sd1, '0, '0);
    issue(OP_TICK,       6'd42, Q_MAX, Q_MIN, Q_MAX, '1);
    issue(OP_TICK,       6'd0,  '0, '0, '0, '0);
    issue(OP_TICK,       6'd63, '0, '0, '0, 32'h0001_0000);
    issue(OP_UNUSED_A,   6'd63, Q_MAX, Q_MAX, Q_MAX, '1);
    issue(OP_UNUSED_B,   6'd7,  Q_MIN, Q_MIN, Q_MIN, '0);
    issue(OP_REMOVE,     6'd63, '0, '0, '0, '0);
    issue(OP_ADD_TORQUE, 6'd63, Q_ONE, Q_ONE, Q_ONE, '0);
    issue(OP_ADD_ENT,    6'd63, '0, '0, '0, '0);
    issue(OP_ADD_VEL,    6'd63, -32'sd3, 32'sd3, -32'sh0001_0001, '0);
    issue(OP_ADD_TORQUE, 6'd63, 32'sh7fff_0000, -32'sh7fff_0000, 32'sd1, '0);
    issue(OP_TICK,       6'd0,  '0, '0, '0, 32'h0000_8000);
    issue(OP_REMOVE,     6'd0,  '0, '0, '0, '0);
    issue(OP_ADD_ENT,    6'd0,  '0, '0, '0, '0);
    drain();

    // random: mostly commands on a small set of live entities
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) eager = ($urandom_range(0, 3) == 0);
      if (n % 200 == 199) drain();
      roll = $urandom_range(0, 99);
      if (roll < 18)      op = OP_SET_POS;
      else if (roll < 34) op = OP_ADD_TORQUE;
      else if (roll < 50) op = OP_ADD_VEL;
      else if (roll < 58) op = OP_TICK;
      else if (roll < 84) op = OP_ADD_ENT;
      else if (roll < 96) op = OP_REMOVE;
      else if (roll < 98) op = OP_UNUSED_A;
      else                op = OP_UNUSED_B;
      ent = $urandom_range(0, 1) ? ENTITY_W'($urandom_range(0, 7))
                                 : ENTITY_W'($urandom_range(0, 63));
      issue(op, ent, pick_value(), pick_value(), pick_value(), pick_delta());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $error("%0d reply words never arrived", tracker.outstanding());
      tracker.errors++;
    end
    if (tracker.errors == 0)
      $display("** entity_euler_integrator: PASSED **");
    else
      $display("** entity_euler_integrator: FAILED **");
    $finish;
  end

endmodule

/* files.f */
rtl/core/eei_pkg.sv
rtl/core/eei_ram.sv
rtl/core/eei_alu.sv
rtl/core/entity_euler_integrator.sv
dv/tb_entity_euler_integrator.sv
